@@ rtl/core/atsp_pkg.sv @@
package atsp_pkg;

    localparam int unsigned STORE_DEPTH = 15;
    localparam int unsigned WINDOW_LEN  = 17;
    localparam int unsigned COUNT_W     = 4;

    localparam logic [COUNT_W-1:0] GT_LEN      = 4'd15;
    localparam logic [COUNT_W-1:0] UTC_MIN_LEN = 4'd9;

    localparam logic [1:0] STATUS_UTC     = 2'd0;
    localparam logic [1:0] STATUS_GT      = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_Z    = 8'h5A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam logic [6:0] UTC_PIVOT  = 7'd50;
    localparam logic [6:0] MAX_MONTH  = 7'd12;
    localparam logic [6:0] MAX_DAY    = 7'd31;
    localparam logic [6:0] MAX_HOUR   = 7'd23;
    localparam logic [6:0] MAX_MINUTE = 7'd59;
    localparam logic [6:0] MAX_SECOND = 7'd61;

    localparam logic [13:0] BASE_2000 = 14'd2000;
    localparam logic [13:0] BASE_1900 = 14'd1900;
    localparam logic [13:0] CENTURY   = 14'd100;

    typedef logic [WINDOW_LEN-1:0][7:0] window_t;

    // Completed string as seen by the parser.
    typedef struct packed {
        window_t            chars;
        logic [COUNT_W-1:0] len;
        logic               too_long;
    } view_t;

    typedef struct packed {
        logic [5:0]  second_value;
        logic [5:0]  minute_value;
        logic [4:0]  hour_value;
        logic [4:0]  day_of_month;
        logic [3:0]  month_index;
        logic [13:0] full_year;
        logic [1:0]  status;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic pair_ok(input logic [7:0] hi, input logic [7:0] lo);
        return is_digit(hi) && is_digit(lo);
    endfunction

    // Only meaningful when both characters are digits.
    function automatic logic [6:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
        return {3'b000, hi[3:0]} * 7'd10 + {3'b000, lo[3:0]};
    endfunction

endpackage

@@ rtl/core/atsp_capture.sv @@
module atsp_capture (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                slot_free,
    output logic                eval_fire,
    output atsp_pkg::view_t     view
);

    logic                             in_valid_reg, in_valid_next;
    logic [7:0]                       in_char_reg;
    logic                             in_last_reg;
    logic [atsp_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             too_long_reg, too_long_next;
    logic [7:0]                       store_reg [atsp_pkg::STORE_DEPTH];
    logic                             advance;
    logic                             full;

    assign full      = (count_reg == atsp_pkg::GT_LEN) || too_long_reg;
    assign advance   = in_valid_reg && (!in_last_reg || slot_free);
    assign eval_fire = in_valid_reg && in_last_reg && slot_free;
    assign s_tready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        if (advance) begin
            if (in_last_reg) begin
                count_next    = '0;
                too_long_next = 1'b0;
            end else if (full) begin
                too_long_next = 1'b1;
            end else begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && !in_last_reg && !full) begin
            store_reg[count_reg] <= in_char_reg;
        end
    end

    // Merge the held byte into the stored string; unused places read as NUL.
    always_comb begin
        view.chars = '0;
        for (int i = 0; i < atsp_pkg::STORE_DEPTH; i++) begin
            if (4'(i) < count_reg) begin
                view.chars[i] = store_reg[i];
            end else if (4'(i) == count_reg && !too_long_reg) begin
                view.chars[i] = in_char_reg;
            end
        end
        view.too_long = full;
        view.len      = full ? count_reg : count_reg + 4'd1;
    end

endmodule

@@ rtl/core/atsp_parse.sv @@
module atsp_parse (
    input  atsp_pkg::view_t   view,
    output atsp_pkg::result_t result
);

    atsp_pkg::window_t b;
    logic              len_ok, utc;
    logic [6:0]        p0, p2, p4, p6, p8, p10, p12;
    logic              d0, d2, d4, d6, d8, d10, d12;
    logic              has_sec, utc_ok, gt_ok, ok;
    logic              utc_term, gt_term;
    logic [13:0]       utc_year, gt_year;
    logic [6:0]        utc_sec;

    assign b      = view.chars;
    assign len_ok = !view.too_long && (view.len >= atsp_pkg::UTC_MIN_LEN);
    assign utc    = (view.len != atsp_pkg::GT_LEN);

    assign p0  = atsp_pkg::pair_val(b[0],  b[1]);
    assign p2  = atsp_pkg::pair_val(b[2],  b[3]);
    assign p4  = atsp_pkg::pair_val(b[4],  b[5]);
    assign p6  = atsp_pkg::pair_val(b[6],  b[7]);
    assign p8  = atsp_pkg::pair_val(b[8],  b[9]);
    assign p10 = atsp_pkg::pair_val(b[10], b[11]);
    assign p12 = atsp_pkg::pair_val(b[12], b[13]);
    assign d0  = atsp_pkg::pair_ok(b[0],  b[1]);
    assign d2  = atsp_pkg::pair_ok(b[2],  b[3]);
    assign d4  = atsp_pkg::pair_ok(b[4],  b[5]);
    assign d6  = atsp_pkg::pair_ok(b[6],  b[7]);
    assign d8  = atsp_pkg::pair_ok(b[8],  b[9]);
    assign d10 = atsp_pkg::pair_ok(b[10], b[11]);
    assign d12 = atsp_pkg::pair_ok(b[12], b[13]);

    // UTCTime: YYMMDDHHMM, optional SS, optional Z.
    assign has_sec  = (b[10] != atsp_pkg::CHAR_Z) && (b[10] != atsp_pkg::CHAR_NUL);
    assign utc_term = has_sec
        ? ((b[12] == atsp_pkg::CHAR_NUL)
           || (b[12] == atsp_pkg::CHAR_Z && b[13] == atsp_pkg::CHAR_NUL))
        : ((b[10] == atsp_pkg::CHAR_NUL)
           || (b[10] == atsp_pkg::CHAR_Z && b[11] == atsp_pkg::CHAR_NUL));
    assign utc_ok = d0
        && d2 && p2 >= 7'd1 && p2 <= atsp_pkg::MAX_MONTH
        && d4 && p4 >= 7'd1 && p4 <= atsp_pkg::MAX_DAY
        && d6 && p6 <= atsp_pkg::MAX_HOUR
        && d8 && p8 <= atsp_pkg::MAX_MINUTE
        && (!has_sec || (d10 && p10 <= atsp_pkg::MAX_SECOND))
        && utc_term;
    assign utc_year = (p0 < atsp_pkg::UTC_PIVOT) ? atsp_pkg::BASE_2000 + 14'(p0)
                                                  : atsp_pkg::BASE_1900 + 14'(p0);
    assign utc_sec  = has_sec ? p10 : 7'd0;

    // GeneralizedTime: YYYYMMDDHHMMSS then Z or end.
    assign gt_term = (b[14] == atsp_pkg::CHAR_NUL)
        || (b[14] == atsp_pkg::CHAR_Z && b[15] == atsp_pkg::CHAR_NUL);
    assign gt_ok = d0 && d2
        && d4 && p4 >= 7'd1 && p4 <= atsp_pkg::MAX_MONTH
        && d6 && p6 >= 7'd1 && p6 <= atsp_pkg::MAX_DAY
        && d8 && p8 <= atsp_pkg::MAX_HOUR
        && d10 && p10 <= atsp_pkg::MAX_MINUTE
        && d12 && p12 <= atsp_pkg::MAX_SECOND
        && gt_term;
    assign gt_year = 14'(p0) * atsp_pkg::CENTURY + 14'(p2);

    assign ok = len_ok && (utc ? utc_ok : gt_ok);

    always_comb begin
        result = '0;
        if (!ok) begin
            result.status = atsp_pkg::STATUS_INVALID;
        end else if (utc) begin
            result.status       = atsp_pkg::STATUS_UTC;
            result.full_year    = utc_year;
            result.month_index  = 4'(p2 - 7'd1);
            result.day_of_month = 5'(p4);
            result.hour_value   = 5'(p6);
            result.minute_value = 6'(p8);
            result.second_value = 6'(utc_sec);
        end else begin
            result.status       = atsp_pkg::STATUS_GT;
            result.full_year    = gt_year;
            result.month_index  = 4'(p4 - 7'd1);
            result.day_of_month = 5'(p6);
            result.hour_value   = 5'(p8);
            result.minute_value = 6'(p10);
            result.second_value = 6'(p12);
        end
    end

endmodule

@@ rtl/core/asn1_time_string_parser.sv @@
// ASN.1 time string parser.
// Input stream: one character per transaction on s_tdata, s_tlast set on the
// final character of a string. Output stream: one transaction per string,
// issued for the transaction that carried s_tlast; characters without s_tlast
// produce nothing on the output.
// A string of 15 characters is decoded as GeneralizedTime, 9 to 14 characters
// as UTCTime; anything else, a bad digit pair, an out-of-range field or
// trailing garbage reports status invalid with all date fields at zero.
// A NUL character terminates the string early.
// m_tvalid rises once the final character has passed the input register and
// then the result register, which takes the decoded result only while free.
// Throughput: one character per cycle while s_tready is high; the decode that
// sits between the input register and the result register is combinational.
// Reset (aresetn low, synchronous): empty both registers and restart string
// collection at the first character; the character store itself holds no
// reset value.
// When the receiver stalls, the result register holds its transaction; further
// characters keep streaming in until a second final character is waiting,
// at which point s_tready drops until the result is taken.
module asn1_time_string_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [15:2] full_year,
                                   // [19:16] month_index, [24:20] day_of_month,
                                   // [29:25] hour_value, [35:30] minute_value,
                                   // [41:36] second_value, [47:42] zero
);

    atsp_pkg::view_t   view;
    atsp_pkg::result_t result;
    atsp_pkg::result_t out_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;
    logic              eval_fire;

    // The result register can take a new transaction when empty or draining.
    assign slot_free = !out_valid_reg || m_tready;

    atsp_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .slot_free (slot_free),
        .eval_fire (eval_fire),
        .view      (view)
    );

    atsp_parse u_parse (
        .view   (view),
        .result (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (eval_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the decoded result whenever a final character is evaluated.
    always_ff @(posedge aclk) begin
        if (eval_fire) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_data_reg};

endmodule

@@ tb/sv/tb_asn1_time_string_parser.sv @@
`timescale 1ns / 100ps

module tb_asn1_time_string_parser;

    typedef logic [7:0] char_q_t[$];

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned YEAR_MAX    = 99;
    localparam int unsigned DRAIN_WAIT  = 10;   // extra wait after the final drain, before the pending check

    // Track the block's character store and predict one date per final character.
    class time_scoreboard;
        logic [7:0]          store [atsp_pkg::STORE_DEPTH];
        logic [7:0]          window [atsp_pkg::WINDOW_LEN];
        int unsigned         count;
        bit                  too_long;
        atsp_pkg::result_t   expected_times[$];
        int unsigned         mismatches;

        function new();
            count = 0;
            too_long = 1'b0;
            mismatches = 0;
        endfunction

        function bit numeral(logic [7:0] c);
            return (c >= atsp_pkg::CHAR_ZERO) && (c <= atsp_pkg::CHAR_NINE);
        endfunction

        // Read a two-digit field at pos; clear ok on a bad pair or out-of-range value.
        function int unsigned take_pair(inout int unsigned pos, inout bit ok,
                                        input int unsigned lo, input int unsigned hi);
            int unsigned v;
            if (!ok || pos > 15 || !numeral(window[pos]) || !numeral(window[pos + 1])) begin
                ok = 1'b0;
                return 0;
            end
            v = (window[pos] - atsp_pkg::CHAR_ZERO) * 10
                + (window[pos + 1] - atsp_pkg::CHAR_ZERO);
            if (v < lo || v > hi) begin
                ok = 1'b0;
                return 0;
            end
            pos = pos + 2;
            return v;
        endfunction

        function atsp_pkg::result_t decode_time();
            atsp_pkg::result_t r;
            int unsigned       len, pos, yr, mo, dy, hr, mi, se;
            bit                ok, utc;
            len = count;
            pos = 0;
            se = 0;
            ok = 1'b1;
            if (too_long || len < atsp_pkg::UTC_MIN_LEN) begin
                ok = 1'b0;
                utc = 1'b0;
            end else begin
                utc = (len != atsp_pkg::GT_LEN);
            end
            foreach (window[i]) window[i] = atsp_pkg::CHAR_NUL;
            if (ok) begin
                for (int i = 0; i < len; i++) window[i] = store[i];
            end
            yr = take_pair(pos, ok, 0, YEAR_MAX);
            if (utc)
                yr = (yr < atsp_pkg::UTC_PIVOT) ? atsp_pkg::BASE_2000 + yr
                                                : atsp_pkg::BASE_1900 + yr;
            else
                yr = yr * atsp_pkg::CENTURY + take_pair(pos, ok, 0, YEAR_MAX);
            mo = take_pair(pos, ok, 1, atsp_pkg::MAX_MONTH);
            dy = take_pair(pos, ok, 1, atsp_pkg::MAX_DAY);
            hr = take_pair(pos, ok, 0, atsp_pkg::MAX_HOUR);
            mi = take_pair(pos, ok, 0, atsp_pkg::MAX_MINUTE);
            if (utc) begin
                if (ok && pos <= 15 && window[pos] != atsp_pkg::CHAR_Z
                    && window[pos] != atsp_pkg::CHAR_NUL)
                    se = take_pair(pos, ok, 0, atsp_pkg::MAX_SECOND);
            end else begin
                se = take_pair(pos, ok, 0, atsp_pkg::MAX_SECOND);
            end
            // Only the end of the string, or Z and then the end, may follow the last field.
            if (ok) begin
                if (pos > 15)
                    ok = 1'b0;
                else if (window[pos] == atsp_pkg::CHAR_NUL)
                    ok = 1'b1;
                else
                    ok = (window[pos] == atsp_pkg::CHAR_Z)
                         && (window[pos + 1] == atsp_pkg::CHAR_NUL);
            end
            r = '0;
            if (!ok) begin
                r.status = atsp_pkg::STATUS_INVALID;
            end else begin
                r.status       = utc ? atsp_pkg::STATUS_UTC : atsp_pkg::STATUS_GT;
                r.full_year    = yr[13:0];
                r.month_index  = 4'(mo - 1);
                r.day_of_month = dy[4:0];
                r.hour_value   = hr[4:0];
                r.minute_value = mi[5:0];
                r.second_value = se[5:0];
            end
            return r;
        endfunction

        // Note one accepted character; queue a prediction on the final one.
        function void take_char(logic [7:0] c, logic last);
            if (too_long || count >= atsp_pkg::STORE_DEPTH) begin
                too_long = 1'b1;
            end else begin
                store[count] = c;
                count++;
            end
            if (last) begin
                expected_times.push_back(decode_time());
                count = 0;
                too_long = 1'b0;
            end
        endfunction

        function void cmp_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(logic [47:0] d);
            atsp_pkg::result_t e, a;
            if (expected_times.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, d);
                mismatches++;
                return;
            end
            e = expected_times.pop_front();
            a = atsp_pkg::result_t'(d[41:0]);
            cmp_field("status", e.status, a.status);
            cmp_field("full_year", e.full_year, a.full_year);
            cmp_field("month_index", e.month_index, a.month_index);
            cmp_field("day_of_month", e.day_of_month, a.day_of_month);
            cmp_field("hour_value", e.hour_value, a.hour_value);
            cmp_field("minute_value", e.minute_value, a.minute_value);
            cmp_field("second_value", e.second_value, a.second_value);
            cmp_field("padding", 0, d[47:42]);
        endfunction

        function int unsigned pending();
            return expected_times.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] char_byte
    logic        s_tlast = 1'b0;      // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;             // [1:0] status, [15:2] full_year, [19:16] month_index,
                                      // [24:20] day_of_month, [29:25] hour_value,
                                      // [35:30] minute_value, [41:36] second_value, [47:42] zero

    time_scoreboard sb = new();

    int unsigned char_count_in = 0;   // accepted character transactions
    int unsigned result_count  = 0;   // accepted result transactions
    int unsigned bytes_sent    = 0;
    int unsigned cycles        = 0;
    int unsigned gap_max_s     = 8;   // sender idle ceiling for the current phase
    int unsigned gap_max_m     = 8;   // receiver stall ceiling for the current phase

    asn1_time_string_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample both channels at the rising edge; check results before noting new characters.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                result_count++;
            end
            if (s_tvalid && s_tready) begin
                sb.take_char(s_tdata, s_tlast);
                char_count_in++;
            end
        end
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_asn1_time_string_parser NOT OK");
            $finish;
        end
    end

    // Receiver: stall a random number of cycles, then hold tready until one result is taken.
    initial begin
        int unsigned stall, target;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, gap_max_m);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            target = result_count + 1;
            while (result_count < target) @(negedge aclk);
        end
    end

    // Drive one character transaction; keep tvalid high across back-to-back transfers.
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap, target;
        gap = $urandom_range(0, gap_max_s);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = c;
        s_tlast = last;
        target = char_count_in + 1;
        do @(negedge aclk); while (char_count_in < target);
        bytes_sent++;
    endtask

    task automatic send_string(input char_q_t q);
        foreach (q[i]) send_char(q[i], i == q.size() - 1);
    endtask

    // Hold the sender idle until every predicted result has been taken.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic char_q_t from_text(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic void push_pair(ref char_q_t q, input int unsigned v);
        q.push_back(8'(atsp_pkg::CHAR_ZERO + v / 10));
        q.push_back(8'(atsp_pkg::CHAR_ZERO + v % 10));
    endfunction

    // Mostly in range, sometimes any two-digit value.
    function automatic int unsigned draw_field(input int unsigned lo, input int unsigned hi);
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, YEAR_MAX);
        return $urandom_range(lo, hi);
    endfunction

    // Build a random string: mostly well-formed times, some corrupted, some pure noise.
    function automatic char_q_t make_string();
        char_q_t     q;
        int unsigned kind, fmt, len, idx;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            len = $urandom_range(1, 20);
            repeat (len) begin
                if ($urandom_range(0, 1))
                    q.push_back(8'(atsp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
                else
                    q.push_back(8'($urandom_range(0, 255)));
            end
            return q;
        end
        // fmt: 0 bare UTC, 1 UTC with seconds, 2 UTC with Z, 3 UTC with seconds and Z, 4 GT
        fmt = $urandom_range(0, 4);
        push_pair(q, $urandom_range(0, YEAR_MAX));
        if (fmt == 4) push_pair(q, $urandom_range(0, YEAR_MAX));
        push_pair(q, draw_field(1, atsp_pkg::MAX_MONTH));
        push_pair(q, draw_field(1, atsp_pkg::MAX_DAY));
        push_pair(q, draw_field(0, atsp_pkg::MAX_HOUR));
        push_pair(q, draw_field(0, atsp_pkg::MAX_MINUTE));
        if (fmt == 1 || fmt >= 3) push_pair(q, draw_field(0, atsp_pkg::MAX_SECOND));
        if (fmt >= 2) q.push_back(atsp_pkg::CHAR_Z);
        if (kind >= 75) begin
            idx = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 4))
                0: q[idx] = 8'($urandom_range(0, 255));
                1: q[idx] = atsp_pkg::CHAR_NUL;
                2: void'(q.pop_back());
                3: q.push_back(8'($urandom_range(0, 255)));
                default: q.push_back(atsp_pkg::CHAR_Z);
            endcase
        end
        return q;
    endfunction

    initial begin
        char_q_t     q;
        int unsigned phase_s [4];
        int unsigned phase_m [4];
        int unsigned phase_end;

        phase_s = '{8, 0, 0, 8};
        phase_m = '{8, 0, 8, 0};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed strings: field extremes, both formats, every way to be invalid.
        send_string(from_text("491231235961Z"));     // 2049, seconds at 61
        send_string(from_text("5001010000"));        // 1950, no seconds, no Z
        send_string(from_text("0001010000Z"));
        send_string(from_text("990101000000"));
        send_string(from_text("99991231235961Z"));   // GeneralizedTime at its maximum
        send_string(from_text("00000101000000Z"));
        send_string(from_text("20240229120000X"));   // GT without the closing Z
        send_string(from_text("2013010000Z"));       // month 13
        send_string(from_text("2000010000Z"));       // month 0
        send_string(from_text("2001320000Z"));       // day 32
        send_string(from_text("2001000000Z"));       // day 0
        send_string(from_text("2001012400Z"));       // hour 24
        send_string(from_text("2001010060Z"));       // minute 60
        send_string(from_text("200101000062"));      // second 62
        send_string(from_text("200101000"));         // nine characters, too short to parse
        send_string(from_text("20010100"));          // bad length
        send_string(from_text("2001010000000000Z")); // overlong
        send_string(from_text("A"));
        send_string(from_text("2001010000ZZ"));      // trailing garbage
        send_string(from_text("20010100005Z"));      // one seconds digit
        send_string(from_text("200101000059ZZ"));
        // A NUL right after the minutes ends the string there: still valid.
        q = from_text("2001010000");
        q.push_back(atsp_pkg::CHAR_NUL);
        q = {q, from_text("ZZZ")};
        send_string(q);
        // A NUL inside a field.
        q = from_text("20010");
        q.push_back(atsp_pkg::CHAR_NUL);
        q = {q, from_text("00000")};
        send_string(q);
        // All-ones byte after a valid prefix.
        q = from_text("2001010000");
        q.push_back(8'hFF);
        send_string(q);
        drain();

        // Random phases: both sides idle, then no idling, then each side stalling alone.
        for (int p = 0; p < 4; p++) begin
            gap_max_s = phase_s[p];
            gap_max_m = phase_m[p];
            phase_end = bytes_sent + 500;
            while (bytes_sent < phase_end) send_string(make_string());
            drain();
        end

        repeat (DRAIN_WAIT) @(negedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("tb_asn1_time_string_parser OK");
        else
            $display("tb_asn1_time_string_parser NOT OK");
        $finish;
    end

endmodule
